### hw/rtl/rar_pkg.sv
// Shared constants for the rational arithmetic reduce core.
package rar_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam int IO_WIDTH = 32;

endpackage

### hw/rtl/rar_front.sv
// Front end: accepts items, forms raw numerator and denominator, flags zero over zero.
module rar_front import rar_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic signed [IO_WIDTH-1:0]   num_a,
  input  logic signed [IO_WIDTH-1:0]   den_a,
  input  logic signed [IO_WIDTH-1:0]   num_b,
  input  logic signed [IO_WIDTH-1:0]   den_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [DATA_WIDTH-1:0]        raw_num,
  output logic [DATA_WIDTH-1:0]        raw_den,
  output logic                         raw_zero
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]            state;
  logic [1:0]            op;
  logic [DATA_WIDTH-1:0] na, da, nb, db;
  logic [DATA_WIDTH-1:0] p0, p1, p2;
  logic [DATA_WIDTH-1:0] x0, y0, x1, y1, x2, y2;

  function automatic logic [DATA_WIDTH-1:0] take(input logic [IO_WIDTH-1:0] v);
    logic [IO_WIDTH+DATA_WIDTH-1:0] e;
    e = {{DATA_WIDTH{v[IO_WIDTH-1]}}, v};
    return e[DATA_WIDTH-1:0];
  endfunction

  always_comb begin
    x0 = na;
    y0 = db;
    x1 = nb;
    y1 = da;
    x2 = da;
    y2 = db;
    unique case (op)
      OP_MUL: begin
        y0 = nb;
      end
      OP_DIV: begin
        y2 = nb;
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign raw_zero  = (raw_num == '0) && (raw_den == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) state <= ST_MUL;
        ST_MUL:  state <= ST_SUM;
        ST_SUM:  state <= ST_DONE;
        ST_DONE: if (out_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op <= opcode;
      na <= take(num_a);
      da <= take(den_a);
      nb <= take(num_b);
      db <= take(den_b);
    end
    if (state == ST_MUL) begin
      p0 <= DATA_WIDTH'(x0 * y0);
      p1 <= DATA_WIDTH'(x1 * y1);
      p2 <= DATA_WIDTH'(x2 * y2);
    end
    if (state == ST_SUM) begin
      raw_den <= p2;
      case (op)
        OP_ADD:  raw_num <= p0 + p1;
        OP_SUB:  raw_num <= p0 - p1;
        default: raw_num <= p0;
      endcase
    end
  end

endmodule

### hw/rtl/rar_queue.sv
// Two-entry queue between the front and back ends.
module rar_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wp, rp;
  logic [1:0]       count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

endmodule

### hw/rtl/rar_back.sv
// Back end: Euclidean gcd, reducing divisions and the result register.
module rar_back import rar_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [DATA_WIDTH-1:0]      raw_num,
  input  logic [DATA_WIDTH-1:0]      raw_den,
  input  logic                       raw_zero,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [IO_WIDTH-1:0] result_num,
  output logic signed [IO_WIDTH-1:0] result_den,
  output logic                       status
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GCD  = 3'd1;
  localparam logic [2:0] ST_DIVN = 3'd2;
  localparam logic [2:0] ST_DIVD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]            state;
  logic [DATA_WIDTH-1:0] rn, rd, p, q, g;
  logic                  zero;
  logic                  div_busy;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH-1:0] dividend, divisor, quo, rem;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH-1:0] rem_sh;
  logic [DATA_WIDTH-1:0] qn;

  function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] x);
    return x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [IO_WIDTH-1:0] outw(input logic [DATA_WIDTH-1:0] x);
    logic [IO_WIDTH+DATA_WIDTH-1:0] e;
    e = {{IO_WIDTH{1'b0}}, x};
    return e[IO_WIDTH-1:0];
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign empty    = (state != ST_OUT);
  assign rem_sh   = {rem[DATA_WIDTH-2:0], dividend[DATA_WIDTH-1]};
  assign trial    = {rem[DATA_WIDTH-1], rem_sh} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      div_busy <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rn   <= raw_num;
            rd   <= raw_den;
            zero <= raw_zero;
            p    <= mag(raw_num);
            q    <= mag(raw_den);
            if (raw_zero) begin
              result_num <= '0;
              result_den <= '0;
            end
            state <= raw_zero ? ST_OUT : ST_GCD;
          end
        end
        ST_GCD: begin
          if (!div_busy) begin
            if (q == '0) begin
              g <= p;
              dividend <= mag(rn);
              divisor <= p;
              rem <= '0;
              cnt <= '0;
              div_busy <= 1'b1;
              state <= ST_DIVN;
            end else begin
              dividend <= p;
              divisor <= q;
              rem <= '0;
              cnt <= '0;
              div_busy <= 1'b1;
            end
          end else if (cnt == CW'(DATA_WIDTH)) begin
            div_busy <= 1'b0;
            p <= q;
            q <= rem;
          end
        end
        ST_DIVN: begin
          if (cnt == CW'(DATA_WIDTH)) begin
            qn <= rn[DATA_WIDTH-1] ? (~quo + 1'b1) : quo;
            dividend <= mag(rd);
            divisor <= g;
            rem <= '0;
            cnt <= '0;
            state <= ST_DIVD;
          end
        end
        ST_DIVD: begin
          if (cnt == CW'(DATA_WIDTH)) begin
            div_busy <= 1'b0;
            result_num <= outw(qn);
            result_den <= outw(rd[DATA_WIDTH-1] ? (~quo + 1'b1) : quo);
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (pop && !empty) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (div_busy && cnt != CW'(DATA_WIDTH)) begin
        cnt <= cnt + 1'b1;
        dividend <= {dividend[DATA_WIDTH-2:0], 1'b0};
        if (!trial[DATA_WIDTH]) begin
          rem <= trial[DATA_WIDTH-1:0];
          quo <= {quo[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[DATA_WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  assign status = zero;

endmodule

### hw/rtl/rational_arith_reduce_core.sv
// Top level of the rational arithmetic core with gcd reduction.
//
// Channel   Direction  Handshake    Payload
// input     in         push / full  opcode, num_a, den_a, num_b, den_b
// result    out        pop / empty  result_num, result_den, status
//
// The front end takes one item at a time through accept, multiply and sum to hand-off.
// The back end loads an item and then runs a one-bit-per-cycle restoring
// divider, first for each Euclid step and then for the two reducing
// divisions of numerator and denominator by the gcd; a zero over
// zero result is ready the cycle after the back end loads it.
// Reset is synchronous; a two-entry queue lets the front keep accepting
// while the back end works or a result waits for pop.
module rational_arith_reduce_core import rar_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 opcode,
  input  logic signed [IO_WIDTH-1:0] num_a,
  input  logic signed [IO_WIDTH-1:0] den_a,
  input  logic signed [IO_WIDTH-1:0] num_b,
  input  logic signed [IO_WIDTH-1:0] den_b,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [IO_WIDTH-1:0] result_num,
  output logic signed [IO_WIDTH-1:0] result_den,
  output logic                       status
);

  localparam int QW = 2 * DATA_WIDTH + 1;

  logic                  in_ready;
  logic                  f_valid, f_ready, q_valid, q_ready;
  logic [DATA_WIDTH-1:0] f_num, f_den;
  logic                  f_zero;
  logic [QW-1:0]         q_data;

  assign full = ~in_ready;

  rar_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst,
    .in_valid (push),
    .in_ready (in_ready),
    .opcode, .num_a, .den_a, .num_b, .den_b,
    .out_valid(f_valid),
    .out_ready(f_ready),
    .raw_num  (f_num),
    .raw_den  (f_den),
    .raw_zero (f_zero)
  );

  rar_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_data ({f_zero, f_den, f_num}),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data (q_data)
  );

  rar_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst,
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .raw_num   (q_data[DATA_WIDTH-1:0]),
    .raw_den   (q_data[2*DATA_WIDTH-1:DATA_WIDTH]),
    .raw_zero  (q_data[QW-1]),
    .empty, .pop, .result_num, .result_den, .status
  );

endmodule
